/* rtl/core/ddo_pkg.sv */
// shared types, constants and the cordic arctangent table for the odometry block
package ddo_pkg;

	localparam int CORDIC_STEPS_DEF = 16;
	localparam int TRIG_BITS_DEF    = 16;

	localparam int ATAN_ENTRIES = 24;

	localparam logic signed [31:0] CORDIC_K30 = 32'sd652032874;
	localparam logic [31:0] GAIN_RESET = 32'd151231243;

	typedef enum logic [1:0] {
		REG_START_X       = 2'd0,
		REG_START_Y       = 2'd1,
		REG_START_HEADING = 2'd2,
		REG_HEADING_GAIN  = 2'd3
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_HMUL,
		ST_HEAD,
		ST_TRIG,
		ST_TWAIT,
		ST_XMUL,
		ST_XACC,
		ST_YACC,
		ST_EMIT
	} seq_state_t;

	// atan(2^-i) as a binary angle, 2^32 per turn
	function automatic logic [31:0] atan_turn(input logic [4:0] idx);
		logic [31:0] v;
		case (idx)
			5'd0:    v = 32'h20000000;
			5'd1:    v = 32'h12E4051E;
			5'd2:    v = 32'h09FB385B;
			5'd3:    v = 32'h051111D4;
			5'd4:    v = 32'h028B0D43;
			5'd5:    v = 32'h0145D7E1;
			5'd6:    v = 32'h00A2F61E;
			5'd7:    v = 32'h00517C55;
			5'd8:    v = 32'h0028BE53;
			5'd9:    v = 32'h00145F2F;
			5'd10:   v = 32'h000A2F98;
			5'd11:   v = 32'h000517CC;
			5'd12:   v = 32'h00028BE6;
			5'd13:   v = 32'h000145F3;
			5'd14:   v = 32'h0000A2FA;
			5'd15:   v = 32'h0000517D;
			5'd16:   v = 32'h000028BE;
			5'd17:   v = 32'h0000145F;
			5'd18:   v = 32'h00000A30;
			5'd19:   v = 32'h00000518;
			5'd20:   v = 32'h0000028C;
			5'd21:   v = 32'h00000146;
			5'd22:   v = 32'h000000A3;
			5'd23:   v = 32'h00000051;
			default: v = 32'h00000000;
		endcase
		return v;
	endfunction

endpackage

/* rtl/core/ddo_cordic.sv */
// iterative cordic, one rotation step per cycle, gives rounded cos and sin of a binary angle
module ddo_cordic
	import ddo_pkg::*;
#(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
	parameter int TRIG_BITS    = TRIG_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [31:0]                 angle,
	output logic                        done,
	output logic signed [TRIG_BITS-1:0] cos_out,
	output logic signed [TRIG_BITS-1:0] sin_out
);

	localparam int CW = $clog2(CORDIC_STEPS + 1);
	localparam int SH = 31 - TRIG_BITS;
	localparam logic signed [32:0] RHALF = 33'(2 ** (SH - 1));
	localparam logic signed [32:0] LIM = 33'(2 ** (TRIG_BITS - 1) - 1);

	logic                        busy_q;
	logic                        done_q;
	logic [CW-1:0]               cnt_q;
	logic                        flip_q;
	logic signed [31:0]          x_q;
	logic signed [31:0]          y_q;
	logic signed [31:0]          z_q;
	logic signed [TRIG_BITS-1:0] cos_q;
	logic signed [TRIG_BITS-1:0] sin_q;

	logic signed [31:0]          xs;
	logic signed [31:0]          ys;
	logic signed [31:0]          at;
	logic                        last;
	logic                        start_flip;
	logic signed [TRIG_BITS-1:0] cr;
	logic signed [TRIG_BITS-1:0] sr;

	function automatic logic signed [TRIG_BITS-1:0] sat_round(input logic signed [31:0] v);
		logic signed [32:0] t;
		logic signed [32:0] r;
		t = 33'(v) + RHALF;
		r = t >>> SH;
		if (r > LIM) begin
			r = LIM;
		end else if (r < -LIM) begin
			r = -LIM;
		end
		return TRIG_BITS'(r);
	endfunction

	assign xs = x_q >>> cnt_q;
	assign ys = y_q >>> cnt_q;
	assign at = signed'(atan_turn(5'(cnt_q)));
	assign last = (cnt_q == CW'(CORDIC_STEPS));
	assign start_flip = angle[31] ^ angle[30];
	assign cr = sat_round(x_q);
	assign sr = sat_round(y_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			flip_q <= start_flip;
			x_q    <= CORDIC_K30;
			y_q    <= '0;
			z_q    <= signed'(angle + {start_flip, 31'b0});
		end else if (busy_q) begin
			if (last) begin
				cos_q <= flip_q ? -cr : cr;
				sin_q <= flip_q ? -sr : sr;
			end else if (!z_q[31]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
		end
	end

	assign done    = done_q;
	assign cos_out = cos_q;
	assign sin_out = sin_q;

endmodule

/* rtl/core/differential_drive_odometry.sv */
// differential-drive dead-reckoning odometry top level
// Each input word carries absolute left and right wheel distances (Q16.16); the block forms
// the wheel steps, advances the binary-angle heading by the gained wheel difference, takes
// cos and sin of the new heading from an iterative CORDIC, and adds the mean step along that
// heading to the Q32.16 X and Y accumulators, then emits the pose as one output word. The
// block takes one word at a time: the CORDIC does one rotation per cycle, and one shared
// 33x33 multiplier forms the heading step and the X and Y increments in turn. The result
// sits in an output register, so the next word is accepted while it waits. Writing start_x,
// start_y or start_heading reloads the whole pose and clears the stored wheel readings;
// heading_gain changes only the gain.
module differential_drive_odometry
	import ddo_pkg::*;
#(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
	parameter int TRIG_BITS    = TRIG_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [47:0]  cfg_data,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [63:0]  s_tdata,  // left_wheel_distance, right_wheel_distance
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata   // x_position, y_position, heading_angle
);

	localparam int AW = TRIG_BITS + 48;
	localparam logic signed [AW-1:0] HALF = AW'(2 ** (TRIG_BITS - 1));

	seq_state_t state_q;
	seq_state_t state_d;

	logic [47:0] start_x_q;
	logic [47:0] start_y_q;
	logic [31:0] start_h_q;
	logic [31:0] gain_q;
	logic [31:0] lp_q;
	logic [31:0] rp_q;
	logic [47:0] x_q;
	logic [47:0] y_q;
	logic [31:0] heading_q;

	logic [31:0] dl_q;
	logic [31:0] dr_q;
	logic signed [65:0] prod_q;

	logic        m_tvalid_q;
	logic [47:0] out_x_q;
	logic [47:0] out_y_q;
	logic [31:0] out_h_q;

	logic                        trig_start;
	logic                        trig_done;
	logic signed [TRIG_BITS-1:0] cos_w;
	logic signed [TRIG_BITS-1:0] sin_w;

	logic signed [32:0] diff;
	logic signed [32:0] sum;
	logic signed [32:0] mul_a;
	logic signed [32:0] mul_b;
	logic [47:0]        hp;
	logic signed [AW-1:0] pext;
	logic signed [AW-1:0] pround;
	logic [47:0]        step48;
	logic               s_acc;
	logic               emit_go;
	logic               reload;

	ddo_cordic #(
		.CORDIC_STEPS(CORDIC_STEPS),
		.TRIG_BITS   (TRIG_BITS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (trig_start),
		.angle  (heading_q),
		.done   (trig_done),
		.cos_out(cos_w),
		.sin_out(sin_w)
	);

	assign diff   = 33'(signed'(dr_q)) - 33'(signed'(dl_q));
	assign sum    = 33'(signed'(dl_q)) + 33'(signed'(dr_q));
	assign hp     = prod_q[47:0] + 48'h8000;
	assign pext   = AW'(prod_q);
	assign pround = (pext + HALF) >>> TRIG_BITS;
	assign step48 = pround[47:0];
	assign s_acc  = s_tvalid && s_tready;
	assign emit_go = (state_q == ST_EMIT) && (!m_tvalid_q || m_tready);
	assign reload = cfg_we && (cfg_index == REG_START_X || cfg_index == REG_START_Y ||
		cfg_index == REG_START_HEADING);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (s_tvalid) state_d = ST_HMUL;
			ST_HMUL:  state_d = ST_HEAD;
			ST_HEAD:  state_d = ST_TRIG;
			ST_TRIG:  state_d = ST_TWAIT;
			ST_TWAIT: if (trig_done) state_d = ST_XMUL;
			ST_XMUL:  state_d = ST_XACC;
			ST_XACC:  state_d = ST_YACC;
			ST_YACC:  state_d = ST_EMIT;
			ST_EMIT:  if (!m_tvalid_q || m_tready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs and multiplier operand select
	always_comb begin
		s_tready   = 1'b0;
		trig_start = 1'b0;
		mul_a      = sum;
		mul_b      = 33'(cos_w);
		case (state_q)
			ST_IDLE: s_tready = 1'b1;
			ST_HMUL: begin
				mul_a = diff;
				mul_b = signed'({1'b0, gain_q});
			end
			ST_TRIG: trig_start = 1'b1;
			ST_XMUL: mul_b = 33'(cos_w);
			ST_XACC: mul_b = 33'(sin_w);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q <= '0;
			start_y_q <= '0;
			start_h_q <= '0;
			gain_q    <= GAIN_RESET;
			lp_q      <= '0;
			rp_q      <= '0;
			x_q       <= '0;
			y_q       <= '0;
			heading_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_START_X:       start_x_q <= cfg_data;
					REG_START_Y:       start_y_q <= cfg_data;
					REG_START_HEADING: start_h_q <= cfg_data[31:0];
					REG_HEADING_GAIN:  gain_q    <= cfg_data[31:0];
					default: ;
				endcase
			end
			if (reload) begin
				x_q       <= (cfg_index == REG_START_X) ? cfg_data : start_x_q;
				y_q       <= (cfg_index == REG_START_Y) ? cfg_data : start_y_q;
				heading_q <= (cfg_index == REG_START_HEADING) ? cfg_data[31:0] : start_h_q;
				lp_q      <= '0;
				rp_q      <= '0;
			end else begin
				if (s_acc) begin
					lp_q <= s_tdata[31:0];
					rp_q <= s_tdata[63:32];
				end
				if (state_q == ST_HEAD) begin
					heading_q <= heading_q + hp[47:16];
				end
				if (state_q == ST_XACC) begin
					x_q <= x_q + step48;
				end
				if (state_q == ST_YACC) begin
					y_q <= y_q + step48;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (s_acc) begin
			dl_q <= s_tdata[31:0] - lp_q;
			dr_q <= s_tdata[63:32] - rp_q;
		end
		if (emit_go) begin
			out_x_q <= x_q;
			out_y_q <= y_q;
			out_h_q <= heading_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (emit_go) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {out_h_q, out_y_q, out_x_q};

	a_trig_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		trig_done |-> state_q == ST_TWAIT)
		else $error("cordic finished outside its wait state");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc |=> state_q == ST_HMUL)
		else $error("accepted word did not start the sequence");

	a_emit_only: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q) == ST_EMIT)
		else $error("output word raised outside the emit step");

endmodule

/* sim/tb_differential_drive_odometry.sv */
`timescale 1ns / 1ps
// self-checking testbench for differential_drive_odometry: pose predictor, directed and random motion with stalls
module tb_differential_drive_odometry;
	import ddo_pkg::*;

	localparam int ROTATIONS = 16;
	localparam int TRIG_W = 16;
	localparam int TRIG_SHIFT = 31 - TRIG_W;
	localparam longint TRIG_MAX = (longint'(1) << (TRIG_W - 1)) - 1;
	localparam longint STEP_HALF = longint'(1) << (TRIG_W - 1);
	localparam longint CORDIC_GAIN_Q30 = 652032874;
	localparam logic [31:0] HEADING_GAIN_RST = 32'd151231243;
	localparam int DRAIN_CYCLES = 40;
	localparam int QUIET_LIMIT = 1000;

	// atan(2^-i), 2^32 per turn
	localparam longint ATAN_BAM [ROTATIONS] = '{
		64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
		64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
		64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
		64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D
	};

	typedef struct packed {
		logic [31:0] heading;
		logic [47:0] y;
		logic [47:0] x;
	} pose_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cfg_we = 1'b0;
	logic [1:0]   cfg_index = '0;
	logic [47:0]  cfg_data = '0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [63:0]  s_tdata = '0;  // left_wheel_distance, right_wheel_distance
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [127:0] m_tdata;       // x_position, y_position, heading_angle

	// predictor state
	logic [47:0] start_x = '0;
	logic [47:0] start_y = '0;
	logic [31:0] start_heading = '0;
	logic [31:0] heading_gain = HEADING_GAIN_RST;
	logic [31:0] prev_left = '0;
	logic [31:0] prev_right = '0;
	logic [47:0] pose_x = '0;
	logic [47:0] pose_y = '0;
	logic [31:0] pose_heading = '0;

	pose_t       expected_pose [$];
	logic [31:0] left_odo = '0;
	logic [31:0] right_odo = '0;
	bit          idle_on = 1'b1;
	int          mismatch_count = 0;
	int          quiet_cycles = 0;

	differential_drive_odometry u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	function automatic longint round_trig(input longint v);
		longint r;
		r = (v + (longint'(1) << (TRIG_SHIFT - 1))) >>> TRIG_SHIFT;
		if (r > TRIG_MAX)
			r = TRIG_MAX;
		if (r < -TRIG_MAX)
			r = -TRIG_MAX;
		return r;
	endfunction

	function automatic void trig_of(input logic [31:0] ang, output longint c, output longint s);
		logic        flip;
		logic [31:0] a;
		longint      x, y, z, nx;
		flip = (ang[31:30] == 2'd1) || (ang[31:30] == 2'd2);
		a = flip ? ang + 32'h8000_0000 : ang;
		z = longint'($signed(a));
		x = CORDIC_GAIN_Q30;
		y = 0;
		for (int i = 0; i < ROTATIONS; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z = z - ATAN_BAM[i];
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z = z + ATAN_BAM[i];
			end
			x = nx;
		end
		c = round_trig(x);
		s = round_trig(y);
		if (flip) begin
			c = -c;
			s = -s;
		end
	endfunction

	function automatic void predict_pose(input logic [31:0] l, input logic [31:0] r);
		logic [31:0] dlu, dru;
		logic [63:0] p;
		longint      dl, dr, c, s, sum;
		pose_t       e;
		dlu = l - prev_left;
		dru = r - prev_right;
		dl = longint'($signed(dlu));
		dr = longint'($signed(dru));
		prev_left = l;
		prev_right = r;
		p = 64'(dr - dl) * 64'(heading_gain) + 64'h8000;
		pose_heading = pose_heading + p[47:16];
		trig_of(pose_heading, c, s);
		sum = dl + dr;
		pose_x = pose_x + 48'((sum * c + STEP_HALF) >>> TRIG_W);
		pose_y = pose_y + 48'((sum * s + STEP_HALF) >>> TRIG_W);
		e.x = pose_x;
		e.y = pose_y;
		e.heading = pose_heading;
		expected_pose.push_back(e);
	endfunction

	function automatic void apply_reg(input cfg_reg_t idx, input logic [47:0] v);
		case (idx)
			REG_START_X: start_x = v;
			REG_START_Y: start_y = v;
			REG_START_HEADING: start_heading = v[31:0];
			REG_HEADING_GAIN: heading_gain = v[31:0];
			default: ;
		endcase
		if (idx != REG_HEADING_GAIN) begin
			pose_x = start_x;
			pose_y = start_y;
			pose_heading = start_heading;
			prev_left = '0;
			prev_right = '0;
		end
	endfunction

	function automatic int small_step();
		int m;
		m = $urandom_range(0, 1 << 19);
		return ($urandom_range(0, 1) != 0) ? m : -m;
	endfunction

	task automatic send_word(input logic [31:0] l, input logic [31:0] r);
		int gap;
		if (idle_on && $urandom_range(0, 2) == 0) begin
			gap = $urandom_range(1, 18);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {r, l};
		do
			@(posedge clk);
		while (!s_tready);
		predict_pose(l, r);
	endtask

	// block must be idle before any register write
	task automatic settle();
		s_tvalid <= 1'b0;
		while (expected_pose.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [47:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		apply_reg(idx, v);
		@(posedge clk);
	endtask

	task automatic load_pose(input logic [47:0] x, input logic [47:0] y, input logic [31:0] h);
		write_reg(REG_START_X, x);
		write_reg(REG_START_Y, y);
		write_reg(REG_START_HEADING, {16'hA5C3, h});
	endtask

	task automatic next_wheels(output logic [31:0] l, output logic [31:0] r);
		int pick;
		int a, b;
		pick = $urandom_range(0, 99);
		a = small_step();
		b = small_step();
		if (pick < 30)
			b = a;
		else if (pick < 45)
			b = -a;
		if (pick < 80) begin
			left_odo = left_odo + a;
			right_odo = right_odo + b;
		end else if (pick < 92) begin
			left_odo = left_odo + $urandom;
			right_odo = right_odo + $urandom;
		end else begin
			left_odo = $urandom;
			right_odo = $urandom;
		end
		l = left_odo;
		r = right_odo;
	endtask

	task automatic test_reset_state();
		send_word(32'h0000_0000, 32'h0000_0000);
		send_word(32'h7FFF_FFFF, 32'h8000_0000);
		send_word(32'h8000_0000, 32'h7FFF_FFFF);
		send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_word(32'h0000_0000, 32'h0000_0000);
	endtask

	// positions wrap at both ends of the 48-bit range
	task automatic test_start_registers();
		settle();
		load_pose(48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000, 32'h0000_0000);
		send_word(32'h0010_0000, 32'h0010_0000);
		send_word(32'h0020_0000, 32'h0020_0000);
		settle();
		load_pose(48'h8000_0000_0000, 48'h8000_0000_0000, 32'hC000_0000);
		send_word(32'h0010_0000, 32'h0010_0000);
		send_word(32'h0030_0000, 32'h0030_0000);
		settle();
		load_pose(48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF, 32'h8000_0000);
		send_word(32'h0010_0000, 32'h0010_0000);
		send_word(32'hFFF0_0000, 32'hFFF0_0000);
	endtask

	task automatic test_heading_quadrants();
		logic [31:0] h [5] = '{32'h3FFF_FFFF, 32'h4000_0000, 32'h7FFF_FFFF,
			32'hC000_0000, 32'hFFFF_FFFF};
		foreach (h[i]) begin
			settle();
			write_reg(REG_START_HEADING, {16'hABCD, h[i]});
			send_word(32'h0003_0000, 32'h0003_0000);
		end
	endtask

	task automatic test_gain_range();
		settle();
		write_reg(REG_HEADING_GAIN, 48'h5A5A_0000_0000);
		send_word(32'h0002_0000, 32'h0004_0000);
		settle();
		write_reg(REG_HEADING_GAIN, 48'hFFFF_FFFF_FFFF);
		send_word(32'h0001_0000, 32'h0005_0000);
		settle();
		write_reg(REG_HEADING_GAIN, {16'h0000, HEADING_GAIN_RST});
		send_word(32'h0004_0000, 32'h0001_0000);
	endtask

	task automatic test_random_motion();
		logic [31:0] l, r;
		for (int phase = 0; phase < 6; phase++) begin
			settle();
			case (phase)
				0: begin
					write_reg(REG_HEADING_GAIN, {16'h0000, HEADING_GAIN_RST});
					load_pose('0, '0, '0);
				end
				1: begin
					load_pose(48'({$urandom, $urandom}), 48'({$urandom, $urandom}), $urandom);
					write_reg(REG_HEADING_GAIN, 48'({$urandom, $urandom}));
				end
				2: write_reg(REG_HEADING_GAIN, 48'({$urandom, 32'h0000_0000}));
				3: begin
					write_reg(REG_HEADING_GAIN, 48'h0000_FFFF_FFFF);
					load_pose(48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000, $urandom);
				end
				4: begin
					write_reg(REG_HEADING_GAIN, 48'($urandom_range(0, 1 << 20)));
					load_pose(48'($signed(small_step())), 48'($signed(small_step())), $urandom);
				end
				default: begin
					write_reg(REG_HEADING_GAIN, 48'({$urandom, $urandom}));
					load_pose(48'({$urandom, $urandom}), 48'({$urandom, $urandom}), $urandom);
				end
			endcase
			repeat (235) begin
				next_wheels(l, r);
				send_word(l, r);
			end
		end
	endtask

	task automatic test_steady_stream();
		logic [31:0] l, r;
		settle();
		idle_on = 1'b0;
		write_reg(REG_HEADING_GAIN, {16'h0000, HEADING_GAIN_RST});
		repeat (140) begin
			next_wheels(l, r);
			send_word(l, r);
		end
	endtask

	always begin : ready_gen
		int n;
		@(posedge clk);
		if (idle_on && $urandom_range(0, 2) == 0) begin
			n = $urandom_range(1, 18);
			m_tready <= 1'b0;
			repeat (n) @(posedge clk);
		end
		m_tready <= 1'b1;
		n = $urandom_range(1, 24);
		repeat (n) @(posedge clk);
	end

	always @(posedge clk) begin : pose_check
		pose_t want, got;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (expected_pose.size() == 0) begin
				$error("unexpected output word %h", m_tdata);
				mismatch_count++;
			end else begin
				want = expected_pose.pop_front();
				if (got.x !== want.x) begin
					$error("x_position: expected %h, got %h", want.x, got.x);
					mismatch_count++;
				end
				if (got.y !== want.y) begin
					$error("y_position: expected %h, got %h", want.y, got.y);
					mismatch_count++;
				end
				if (got.heading !== want.heading) begin
					$error("heading_angle: expected %h, got %h", want.heading, got.heading);
					mismatch_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("** differential_drive_odometry: FAILED **");
			$finish;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_start_registers();
		test_heading_quadrants();
		test_gain_range();
		test_random_motion();
		test_steady_stream();
		settle();
		if (mismatch_count == 0 && expected_pose.size() == 0)
			$display("** differential_drive_odometry: PASSED **");
		else
			$display("** differential_drive_odometry: FAILED **");
		$finish;
	end

endmodule
